// ===== rtl/btk_pkg.sv =====
package btk_pkg;

    localparam int ID_W          = 24;
    localparam int SCORE_W       = 32;
    localparam int RANK_W        = 4;
    localparam int MAX_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 5'd16;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   ins;
    } cell_ctrl_t;

endpackage

// ===== rtl/btk_cell.sv =====
module btk_cell #(
    parameter int IDX    = 0,
    parameter int FILL_W = 5
) (
    input  logic                clk,
    input  btk_pkg::cell_ctrl_t ctrl,
    input  logic [FILL_W-1:0]   fill,
    input  logic                prev_keep,
    input  btk_pkg::entry_t     prev_entry,
    input  btk_pkg::entry_t     next_entry,
    output logic                keep,
    output btk_pkg::entry_t     entry
);

    btk_pkg::entry_t entry_reg;
    btk_pkg::entry_t entry_next;

    // The cell keeps its entry on an insert when it is occupied and scores
    // at least as high as the new pair.
    assign keep  = (FILL_W'(IDX) < fill) && (entry_reg.score >= ctrl.ins.score);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            btk_pkg::OP_INSERT:
            begin
                if (!keep)
                begin
                    entry_next = prev_keep ? ctrl.ins : prev_entry;
                end
            end
            btk_pkg::OP_ROTATE:
            begin
                entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/bounded_top_k_list_core.sv =====
// Channel   Direction  Transfer
// s_*       in         one command: kind in tuser, id and score in tdata
// m_*       out        one ranked entry, tlast on the final one of a readout
// APB       in         max_entries register at byte address 0
//
// An insert or a clear never holds the input. After its transfer a readout
// holds the input while the row of cells rotates once around, and longer
// while an entry is due but the output register is full and m_tready is low.
// An empty readout holds the input until the output register is free to
// take its empty result, which waits there on m_tready.
// Reset empties the list at once and sets max_entries to 16.
module bounded_top_k_list_core #(
    parameter int DEPTH = btk_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // doc_id[23:0], doc_score[55:24]
    input  logic [1:0]  s_tuser,  // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // out_id[23:0], out_score[55:24], out_rank[59:56]
    output logic        m_tlast,
    output logic        m_tuser,  // list_empty
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W  = (FILL_W > btk_pkg::MAX_W) ? FILL_W : btk_pkg::MAX_W;

    btk_pkg::state_t           state_reg;
    btk_pkg::state_t           state_next;
    logic [btk_pkg::MAX_W-1:0] max_entries_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic [FILL_W-1:0]         fill_next;
    logic [IDX_W-1:0]          cnt_reg;
    logic [IDX_W-1:0]          cnt_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    btk_pkg::entry_t           m_entry_reg;
    logic [btk_pkg::RANK_W-1:0] m_rank_reg;
    logic                      m_last_reg;
    logic                      m_empty_reg;

    btk_pkg::cell_ctrl_t       ctrl;
    btk_pkg::entry_t           entries [DEPTH];
    logic [DEPTH-1:0]          keeps;
    logic [FILL_W-1:0]         lim;
    logic [FILL_W-1:0]         cfg_lim;
    logic                      accept;
    logic                      cfg_write;
    logic                      drop;
    logic                      slot_free;
    logic                      emit;
    logic                      emit_empty;
    logic                      cnt_end;

    function automatic logic [FILL_W-1:0] clamp_lim(input logic [btk_pkg::MAX_W-1:0] m);
        logic [LIM_W-1:0] mx;
        begin
            mx = LIM_W'(m);
            if (mx == '0)
            begin
                mx = LIM_W'(1);
            end
            else if (mx > LIM_W'(DEPTH))
            begin
                mx = LIM_W'(DEPTH);
            end
            return FILL_W'(mx);
        end
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : 32'(max_entries_reg);

    assign lim       = clamp_lim(max_entries_reg);
    assign cfg_lim   = clamp_lim(pwdata[btk_pkg::MAX_W-1:0]);
    assign s_tready  = (state_reg == btk_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign drop      = keeps[IDX_W'(lim - 1'b1)];
    assign slot_free = !m_valid_reg || m_tready;
    assign cnt_end   = (cnt_reg == IDX_W'(DEPTH - 1));

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            btk_cell #(
                .IDX    (gi),
                .FILL_W (FILL_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .fill       (fill_reg),
                .prev_keep  ((gi == 0) ? 1'b1 : keeps[(gi == 0) ? 0 : gi - 1]),
                .prev_entry (entries[(gi == 0) ? 0 : gi - 1]),
                .next_entry (entries[(gi + 1) % DEPTH]),
                .keep       (keeps[gi]),
                .entry      (entries[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        ctrl.op        = btk_pkg::OP_HOLD;
        ctrl.ins.id    = s_tdata[23:0];
        ctrl.ins.score = s_tdata[55:24];
        emit           = 1'b0;
        emit_empty     = 1'b0;
        m_valid_next   = m_valid_reg && !m_tready;
        case (state_reg)
            btk_pkg::ST_IDLE:
            begin
                if (cfg_write && (fill_reg > cfg_lim))
                begin
                    fill_next = cfg_lim;
                end
                if (accept)
                begin
                    case (s_tuser)
                        btk_pkg::KIND_INSERT:
                        begin
                            ctrl.op = btk_pkg::OP_INSERT;
                            if (!drop)
                            begin
                                fill_next = (fill_reg < lim) ? fill_reg + 1'b1 : lim;
                            end
                        end
                        btk_pkg::KIND_READ:
                        begin
                            state_next = btk_pkg::ST_READ;
                            cnt_next   = '0;
                        end
                        btk_pkg::KIND_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
            end
            btk_pkg::ST_READ:
            begin
                if (fill_reg == '0)
                begin
                    if (slot_free)
                    begin
                        emit_empty   = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = btk_pkg::ST_IDLE;
                    end
                end
                else if (FILL_W'(cnt_reg) >= fill_reg || slot_free)
                begin
                    // Entries still due leave cell 0 through the output
                    // register; the rest of the turn restores the order.
                    emit    = FILL_W'(cnt_reg) < fill_reg;
                    ctrl.op = btk_pkg::OP_ROTATE;
                    if (emit)
                    begin
                        m_valid_next = 1'b1;
                    end
                    if (cnt_end)
                    begin
                        cnt_next   = '0;
                        state_next = btk_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = btk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= btk_pkg::ST_IDLE;
            max_entries_reg <= btk_pkg::MAX_ENTRIES_RESET;
            fill_reg        <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write)
            begin
                max_entries_reg <= pwdata[btk_pkg::MAX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_entry_reg <= entries[0];
            m_rank_reg  <= btk_pkg::RANK_W'(cnt_reg);
            m_last_reg  <= (FILL_W'(cnt_reg) + 1'b1) == fill_reg;
            m_empty_reg <= 1'b0;
        end
        else if (emit_empty)
        begin
            m_entry_reg <= '0;
            m_rank_reg  <= '0;
            m_last_reg  <= 1'b1;
            m_empty_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_rank_reg, m_entry_reg.score, m_entry_reg.id};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_empty_reg;

`ifndef SYNTHESIS
    a_fill_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= lim)
        else $error("list holds more entries than the limit");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 64'd0))
        else $error("empty readout result is malformed");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == btk_pkg::KIND_INSERT && !drop && fill_reg < lim)
        |=> fill_reg == FILL_W'($past(fill_reg) + 1'b1))
        else $error("accepted insert did not grow the list");

    a_read_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == btk_pkg::ST_READ && fill_reg != '0 && !cnt_end)
        |=> state_reg == btk_pkg::ST_READ)
        else $error("readout ended before a full turn");
`endif

endmodule
